>>> hdl/irpd_pkg.sv
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CNT_W      = 6;
  localparam int FRAME_BITS = 32;
  localparam int WORD_W     = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;

  localparam logic [TICK_W-1:0] HDR_MARK_RST   = 16'd18000;
  localparam logic [TICK_W-1:0] HDR_SPACE_RST  = 16'd9000;
  localparam logic [TICK_W-1:0] ONE_SPACE_RST  = 16'd3380;
  localparam logic [TICK_W-1:0] ZERO_SPACE_RST = 16'd1120;
  localparam logic [TICK_W-1:0] TOLERANCE_RST  = 16'd400;

  typedef struct packed {
    logic              pin_level;
    logic [TICK_W-1:0] pulse_width;
    logic              tx_busy;
  } in_item_t;

  typedef struct packed {
    logic [3:0] version;
    logic       seq_bit;
    logic [2:0] client_id;
    logic [3:0] session_num;
    logic [3:0] op_code;
    logic [7:0] payload;
    logic [7:0] checksum;
    logic       checksum_ok;
  } out_item_t;

  // classified edge, handed from the front to the back
  typedef struct packed {
    logic high;
    logic hdr_mark;
    logic hdr_space;
    logic one_bit;
    logic zero_bit;
  } edge_class_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_SPACE = 3'b010,
    PH_DATA  = 3'b100
  } phase_t;

  // strict window lo < w < hi, lo clamped at zero, hi without wrap
  function automatic logic in_window(input logic [TICK_W-1:0] w,
                                     input logic [TICK_W-1:0] nominal,
                                     input logic [TICK_W-1:0] tol);
    logic [TICK_W-1:0] lo;
    logic [TICK_W:0]   hi;
    lo = (nominal > tol) ? (nominal - tol) : '0;
    hi = {1'b0, nominal} + {1'b0, tol};
    return (w > lo) && ({1'b0, w} < hi);
  endfunction

endpackage

>>> hdl/irpd_front.sv
`timescale 1ns / 1ps

module irpd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpd_pkg::TICK_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  irpd_pkg::in_item_t             in_item,
  input  logic                           q_full,
  output logic                           push,
  output irpd_pkg::edge_class_t          push_item
);

  logic [irpd_pkg::TICK_W-1:0] hdr_mark_ticks;
  logic [irpd_pkg::TICK_W-1:0] hdr_space_ticks;
  logic [irpd_pkg::TICK_W-1:0] one_space_ticks;
  logic [irpd_pkg::TICK_W-1:0] zero_space_ticks;
  logic [irpd_pkg::TICK_W-1:0] tolerance_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_mark_ticks   <= irpd_pkg::HDR_MARK_RST;
      hdr_space_ticks  <= irpd_pkg::HDR_SPACE_RST;
      one_space_ticks  <= irpd_pkg::ONE_SPACE_RST;
      zero_space_ticks <= irpd_pkg::ZERO_SPACE_RST;
      tolerance_ticks  <= irpd_pkg::TOLERANCE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        irpd_pkg::REG_HDR_MARK:   hdr_mark_ticks   <= cfg_data;
        irpd_pkg::REG_HDR_SPACE:  hdr_space_ticks  <= cfg_data;
        irpd_pkg::REG_ONE_SPACE:  one_space_ticks  <= cfg_data;
        irpd_pkg::REG_ZERO_SPACE: zero_space_ticks <= cfg_data;
        irpd_pkg::REG_TOLERANCE:  tolerance_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  // drop edges seen while the transmitter is busy
  assign push = in_valid && !in_stall && !in_item.tx_busy;

  always_comb begin
    push_item.high      = in_item.pin_level;
    push_item.hdr_mark  = irpd_pkg::in_window(in_item.pulse_width, hdr_mark_ticks,
                                              tolerance_ticks);
    push_item.hdr_space = irpd_pkg::in_window(in_item.pulse_width, hdr_space_ticks,
                                              tolerance_ticks);
    push_item.one_bit   = irpd_pkg::in_window(in_item.pulse_width, one_space_ticks,
                                              tolerance_ticks);
    push_item.zero_bit  = irpd_pkg::in_window(in_item.pulse_width, zero_space_ticks,
                                              tolerance_ticks);
  end

endmodule

>>> hdl/irpd_queue.sv
`timescale 1ns / 1ps

module irpd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  irpd_pkg::edge_class_t push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  q_valid,
  output irpd_pkg::edge_class_t q_item
);

  irpd_pkg::edge_class_t mem [irpd_pkg::QUEUE_DEPTH];

  logic [irpd_pkg::QPTR_W-1:0] wr_ptr;
  logic [irpd_pkg::QPTR_W-1:0] rd_ptr;
  logic [irpd_pkg::QCNT_W-1:0] count;

  assign full    = (count == irpd_pkg::QCNT_W'(irpd_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == irpd_pkg::QPTR_W'(irpd_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == irpd_pkg::QPTR_W'(irpd_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= irpd_pkg::QCNT_W'(irpd_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

>>> hdl/irpd_back.sv
`timescale 1ns / 1ps

module irpd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  irpd_pkg::edge_class_t q_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output irpd_pkg::out_item_t   out_item
);

  irpd_pkg::phase_t                 phase, phase_next;
  logic [irpd_pkg::CNT_W-1:0]       bit_count, bit_count_next;
  logic [irpd_pkg::WORD_W-1:0]      shift_word, shift_word_next;
  logic [irpd_pkg::CNT_W:0]         count_inc;
  logic                             emit;
  logic [7:0]                       b1, b2, b3, b4;
  logic [7:0]                       byte_sum;

  // advance only when the output register has room for a result
  assign pop = q_valid && (!out_valid || !out_stall);

  assign count_inc = {1'b0, bit_count} + 1'b1;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_word_next = shift_word;
    emit            = 1'b0;
    if (pop) begin
      case (phase)
        irpd_pkg::PH_HUNT: begin
          if (q_item.high && q_item.hdr_mark) begin
            phase_next = irpd_pkg::PH_SPACE;
          end
        end
        irpd_pkg::PH_SPACE: begin
          if (!q_item.high && q_item.hdr_space) begin
            bit_count_next  = '0;
            shift_word_next = '0;
            phase_next      = irpd_pkg::PH_DATA;
          end else begin
            phase_next = irpd_pkg::PH_HUNT;
          end
        end
        irpd_pkg::PH_DATA: begin
          if (!q_item.high) begin
            shift_word_next = {shift_word[irpd_pkg::WORD_W-2:0], q_item.one_bit};
            if (!q_item.one_bit && !q_item.zero_bit) begin
              phase_next = irpd_pkg::PH_HUNT;
            end else if (count_inc >= (irpd_pkg::CNT_W + 1)'(irpd_pkg::FRAME_BITS)) begin
              emit           = 1'b1;
              bit_count_next = '0;
              phase_next     = irpd_pkg::PH_HUNT;
            end else begin
              bit_count_next = count_inc[irpd_pkg::CNT_W-1:0];
            end
          end
        end
        default: phase_next = irpd_pkg::PH_SPACE;
      endcase
    end
  end

  assign b1       = shift_word_next[31:24];
  assign b2       = shift_word_next[23:16];
  assign b3       = shift_word_next[15:8];
  assign b4       = shift_word_next[7:0];
  assign byte_sum = b1 + b2 + b3;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= irpd_pkg::PH_HUNT;
      bit_count  <= '0;
      shift_word <= '0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_word <= shift_word_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.version     <= b1[7:4];
      out_item.seq_bit     <= b1[3];
      out_item.client_id   <= b1[2:0];
      out_item.session_num <= b2[7:4];
      out_item.op_code     <= b2[3:0];
      out_item.payload     <= b3;
      out_item.checksum    <= b4;
      out_item.checksum_ok <= (byte_sum == b4);
    end
  end

  a_count_below_frame: assert property (@(posedge clk) disable iff (rst)
    bit_count < irpd_pkg::CNT_W'(irpd_pkg::FRAME_BITS))
    else $error("bit count reached frame length without emitting");

  a_emit_restarts: assert property (@(posedge clk) disable iff (rst)
    emit |=> (phase == irpd_pkg::PH_HUNT) && (bit_count == '0) && out_valid)
    else $error("frame end did not restart header hunt");

  a_emit_from_data: assert property (@(posedge clk) disable iff (rst)
    emit |-> (phase == irpd_pkg::PH_DATA) && !q_item.high)
    else $error("result emitted outside data phase");

endmodule

>>> hdl/ir_pulse_distance_receiver_unit.sv
`timescale 1ns / 1ps

// Pulse-distance IR receiver. Each input item is one edge on the receiver
// pin (level after the edge, ticks since the previous edge, transmitter
// busy); items taken while the transmitter is busy are dropped. The block
// takes one item per clock unless stalled: the front classifies the width
// against the header and bit windows in the accept cycle and writes the
// result into a two-entry queue, and the back runs the header/data phase
// machine on one queued edge per cycle unless the output stalls. A completed
// 32-bit frame is written to the output register when the back pops its last
// edge. The input stalls only when the queue is full, which happens
// when a result waits at a stalled output. Configuration registers sit on a
// plain write port, index 0 to 4 in the order header mark, header space, one
// space, zero space, tolerance; write them only while no edge is in flight.
module ir_pulse_distance_receiver_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpd_pkg::TICK_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  irpd_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output irpd_pkg::out_item_t            out_item
);

  logic                  q_full;
  logic                  push;
  irpd_pkg::edge_class_t push_item;
  logic                  pop;
  logic                  q_valid;
  irpd_pkg::edge_class_t q_item;

  irpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  irpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  irpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
